// ===== rtl/core/tkh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tkh_pkg;

    // field widths of one beat
    localparam int SCORE_W = 32;
    localparam int DOC_W   = 32;
    localparam int CFG_W   = 11;
    localparam int COUNT_W = 11;

    // reset value of the kept-entry limit
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    // command codes carried in tuser
    localparam logic CMD_OFFER = 1'b0;
    localparam logic CMD_POP   = 1'b1;

    // one heap entry, score in the upper half
    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic        [DOC_W-1:0]   doc;
    } entry_t;

    // one result beat
    typedef struct packed {
        logic                      accepted;
        logic                      popped_valid;
        logic signed [SCORE_W-1:0] popped_score;
        logic        [DOC_W-1:0]   popped_doc;
        logic signed [SCORE_W-1:0] min_score;
        logic        [COUNT_W-1:0] entry_count;
    } result_t;

    // signed score order, equal counts as not less
    function automatic logic score_less(input logic signed [SCORE_W-1:0] a,
                                        input logic signed [SCORE_W-1:0] b);
        return a < b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tkh_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tkh_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                  aclk,
    input  wire logic                  wr_en,
    input  wire logic [AW-1:0]         wr_addr,
    input  wire tkh_pkg::entry_t       wr_data,
    input  wire logic [AW-1:0]         rd_addr_a,
    input  wire logic [AW-1:0]         rd_addr_b,
    output tkh_pkg::entry_t            rd_data_a,
    output tkh_pkg::entry_t            rd_data_b
);
    import tkh_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_a_reg;
    entry_t rd_b_reg;

    // one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tkh_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tkh_seq #(
    parameter int CAPACITY = 1024
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // item side
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  in_cmd,
    input  wire tkh_pkg::entry_t       in_entry,
    // limit on kept entries, already clamped
    input  wire logic [((($clog2(CAPACITY+1)) > 11) ? $clog2(CAPACITY+1) : 11)-1:0] k_lim,
    // result side
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output tkh_pkg::result_t           res
);
    import tkh_pkg::*;

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int KW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int CW    = AW + 2;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_UP_RD    = 7'b0000010,
        S_UP_CMP   = 7'b0000100,
        S_LAST_GET = 7'b0001000,
        S_DN_RD    = 7'b0010000,
        S_DN_CMP   = 7'b0100000,
        S_RESULT   = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    entry_t             item_reg, item_next;
    entry_t             root_reg, root_next;
    entry_t             pop_reg, pop_next;
    logic               acc_reg, acc_next;
    logic               pv_reg, pv_next;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    entry_t             wr_data;
    logic [AW-1:0]      rd_addr_a;
    logic [AW-1:0]      rd_addr_b;
    entry_t             rd_data_a;
    entry_t             rd_data_b;

    logic [AW-1:0]      par_idx;
    logic [CW-1:0]      left_idx;
    logic [CW-1:0]      right_idx;
    logic [CW-1:0]      cnt_cw;
    logic [KW-1:0]      cnt_kw;
    logic               has_right;
    logic               pick_right;
    entry_t             child;
    logic [CW-1:0]      child_idx;
    logic [CNT_W-1:0]   cnt_dec;

    tkh_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // heap index arithmetic
    assign par_idx   = AW'(pos_reg - 1'b1) >> 1;
    assign left_idx  = (CW'(pos_reg) << 1) | CW'(1);
    assign right_idx = left_idx + CW'(1);
    assign cnt_cw    = CW'(cnt_reg);
    assign cnt_kw    = KW'(cnt_reg);
    assign cnt_dec   = cnt_reg - CNT_W'(1);

    // pick the smaller child, left wins a tie
    assign has_right  = right_idx < cnt_cw;
    assign pick_right = has_right && score_less(rd_data_b.score, rd_data_a.score);
    assign child      = pick_right ? rd_data_b : rd_data_a;
    assign child_idx  = pick_right ? right_idx : left_idx;

    // root copy follows every write to the top slot
    assign root_next = (wr_en && (wr_addr == '0)) ? wr_data : root_reg;

    // sequencer
    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        item_next  = item_reg;
        pop_next   = pop_reg;
        acc_next   = acc_reg;
        pv_next    = pv_reg;
        wr_en      = 1'b0;
        wr_addr    = pos_reg;
        wr_data    = item_reg;
        rd_addr_a  = par_idx;
        rd_addr_b  = right_idx[AW-1:0];
        res_valid  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                // fetch the last entry in case this is a pop
                rd_addr_a = cnt_dec[AW-1:0];
                if (in_valid) begin
                    acc_next  = 1'b0;
                    pv_next   = 1'b0;
                    pop_next  = '0;
                    item_next = in_entry;
                    pos_next  = '0;
                    if (in_cmd == CMD_OFFER) begin
                        if (cnt_kw < k_lim) begin
                            // room left: append and sift up
                            pos_next   = cnt_reg[AW-1:0];
                            cnt_next   = cnt_reg + CNT_W'(1);
                            acc_next   = 1'b1;
                            state_next = S_UP_RD;
                        end else if ((cnt_reg != '0) &&
                                     !score_less(in_entry.score, root_reg.score)) begin
                            // full: replace the root and sift down
                            acc_next   = 1'b1;
                            state_next = S_DN_RD;
                        end else begin
                            state_next = S_RESULT;
                        end
                    end else begin
                        if (cnt_reg != '0) begin
                            pv_next    = 1'b1;
                            pop_next   = root_reg;
                            cnt_next   = cnt_dec;
                            state_next = S_LAST_GET;
                        end else begin
                            state_next = S_RESULT;
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (pos_reg == '0) begin
                    wr_en      = 1'b1;
                    state_next = S_RESULT;
                end else begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                wr_en = 1'b1;
                if (score_less(item_reg.score, rd_data_a.score)) begin
                    // parent moves down one level
                    wr_data    = rd_data_a;
                    pos_next   = par_idx;
                    state_next = S_UP_RD;
                end else begin
                    state_next = S_RESULT;
                end
            end
            S_LAST_GET: begin
                // last entry moves to the root
                item_next  = rd_data_a;
                state_next = S_DN_RD;
            end
            S_DN_RD: begin
                rd_addr_a = left_idx[AW-1:0];
                if (left_idx >= cnt_cw) begin
                    wr_en      = 1'b1;
                    state_next = S_RESULT;
                end else begin
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                wr_en = 1'b1;
                if (score_less(child.score, item_reg.score)) begin
                    // smaller child moves up one level
                    wr_data    = child;
                    pos_next   = child_idx[AW-1:0];
                    state_next = S_DN_RD;
                end else begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        pos_reg  <= pos_next;
        item_reg <= item_next;
        root_reg <= root_next;
        pop_reg  <= pop_next;
        acc_reg  <= acc_next;
        pv_reg   <= pv_next;
    end

    assign in_ready = (state_reg == S_IDLE);

    // result beat
    always_comb begin
        res.accepted     = acc_reg;
        res.popped_valid = pv_reg;
        res.popped_score = pop_reg.score;
        res.popped_doc   = pop_reg.doc;
        res.min_score    = ((cnt_kw >= k_lim) && (cnt_reg != '0)) ? root_reg.score : '0;
        res.entry_count  = cnt_kw[COUNT_W-1:0];
    end

endmodule

`default_nettype wire

// ===== rtl/core/top_k_score_min_heap.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Top-K score keeper: holds the best-scoring (score, document id) entries in a
// binary min-heap held in a 64-bit wide memory, lowest score at the root. An
// offer (tuser 0) is appended while fewer than K entries are held, otherwise it
// replaces the root when its score is not below the root score; a pop (tuser 1)
// returns the root. Each input beat gives one result beat with the count and
// the root score, which reads 0 until the heap is full. K comes from the
// configuration channel (0 acts as 1, values above CAPACITY saturate). Items are
// handled one at a time: each level that an entry moves in a sift takes one
// memory read step and one compare/write step, a sift that stops on a compare
// takes one more compare/write step, and a pop first fetches the last entry.
// At CAPACITY 1024 the longest sift is an append that rises ten levels to the
// root. A rejected offer or an empty pop goes straight to the result. A
// finished result waits in the output register and the next item is taken once
// the result has left the sequencer.
module top_k_score_min_heap #(
    parameter int CAPACITY = 1024
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    // input item beat
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [63:0]   s_tdata,   // score [31:0], doc_id [63:32]
    input  wire logic [0:0]    s_tuser,   // cmd [0]
    // result beat
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [111:0]       m_tdata,   // popped_score [31:0], popped_doc [63:32],
                                          // min_score [95:64], entry_count [106:96]
    output logic [1:0]         m_tuser,   // accepted [0], popped_valid [1]
    // limit on kept entries
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [10:0]   cfg_data   // capacity_in_use
);
    import tkh_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int KW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    logic [CFG_W-1:0] cap_reg;
    logic [KW-1:0]    cap_kw;
    logic [KW-1:0]    k_lim;
    entry_t           in_entry;
    logic             res_valid;
    logic             res_ready;
    result_t          res;
    logic             m_valid_reg;
    result_t          m_res_reg;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            cap_reg <= cfg_data;
        end
    end

    // clamp K into 1..CAPACITY
    assign cap_kw = KW'(cap_reg);
    always_comb begin
        if (cap_reg == '0) begin
            k_lim = KW'(1);
        end else if (cap_kw > KW'(CAPACITY)) begin
            k_lim = KW'(CAPACITY);
        end else begin
            k_lim = cap_kw;
        end
    end

    assign in_entry.score = s_tdata[31:0];
    assign in_entry.doc   = s_tdata[63:32];

    tkh_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser[0]),
        .in_entry  (in_entry),
        .k_lim     (k_lim),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = {m_res_reg.popped_valid, m_res_reg.accepted};
    assign m_tdata  = {5'd0, m_res_reg.entry_count, m_res_reg.min_score,
                       m_res_reg.popped_doc, m_res_reg.popped_score};

    // one item at a time: no new beat right after one is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in flight");

    // an offer result never carries a popped entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("result both accepted and popped");

    // no popped entry means zero popped fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[1]) |-> (m_tdata[63:0] == 64'd0))
        else $error("popped fields set without a popped entry");

endmodule

`default_nettype wire

// ===== dv/tb_top_k_score_min_heap.sv =====
`timescale 1ns / 1ps

module tb_top_k_score_min_heap;

    import tkh_pkg::*;

    localparam int HEAP_DEPTH    = 1024;
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT   = 2000;

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [63:0]         s_tdata   = '0;   // score [31:0], doc_id [63:32]
    logic [0:0]          s_tuser   = '0;   // cmd [0]
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [111:0]        m_tdata;          // popped_score [31:0], popped_doc [63:32],
                                           // min_score [95:64], entry_count [106:96]
    logic [1:0]          m_tuser;          // accepted [0], popped_valid [1]
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data  = '0;

    top_k_score_min_heap #(
        .CAPACITY (HEAP_DEPTH)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // shadow heap of kept entries
    logic signed [SCORE_W-1:0] kept_score [HEAP_DEPTH];
    logic        [DOC_W-1:0]   kept_doc   [HEAP_DEPTH];
    int unsigned               kept_n     = 0;
    logic        [CFG_W-1:0]   limit_reg  = CFG_RESET;

    result_t predicted_results [$];
    int      mismatch_count = 0;
    int      idle_pct       = 0;
    int      stall_pct      = 0;
    int      quiet_cycles   = 0;

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // kept-entry limit as the block applies it
    function automatic int unsigned top_k_limit();
        int unsigned k;
        k = limit_reg;
        if (k == 0) k = 1;
        if (k > HEAP_DEPTH) k = HEAP_DEPTH;
        return k;
    endfunction

    // move the entry at pos toward the root while it is strictly lower
    function automatic void heap_rise(input int unsigned pos);
        logic signed [SCORE_W-1:0] s;
        logic        [DOC_W-1:0]   d;
        int unsigned               p;
        int unsigned               par;
        s = kept_score[pos];
        d = kept_doc[pos];
        p = pos;
        while (p > 0) begin
            par = (p - 1) >> 1;
            if (!(s < kept_score[par])) break;
            kept_score[p] = kept_score[par];
            kept_doc[p]   = kept_doc[par];
            p = par;
        end
        kept_score[p] = s;
        kept_doc[p]   = d;
    endfunction

    // move the root down; equal children pick the left one, equal stops
    function automatic void heap_sink();
        logic signed [SCORE_W-1:0] s;
        logic        [DOC_W-1:0]   d;
        int unsigned               p;
        int unsigned               c;
        s = kept_score[0];
        d = kept_doc[0];
        p = 0;
        forever begin
            c = 2 * p + 1;
            if (c >= kept_n) break;
            if (c + 1 < kept_n && kept_score[c + 1] < kept_score[c]) c = c + 1;
            if (!(kept_score[c] < s)) break;
            kept_score[p] = kept_score[c];
            kept_doc[p]   = kept_doc[c];
            p = c;
        end
        kept_score[p] = s;
        kept_doc[p]   = d;
    endfunction

    // apply one command to the shadow heap and return the result beat it gives
    function automatic result_t apply_heap_cmd(input logic cmd,
                                               input logic signed [SCORE_W-1:0] sc,
                                               input logic [DOC_W-1:0] doc);
        result_t     r;
        int unsigned k;
        r = '0;
        k = top_k_limit();
        if (cmd == CMD_OFFER) begin
            if (kept_n < k) begin
                kept_score[kept_n] = sc;
                kept_doc[kept_n]   = doc;
                kept_n = kept_n + 1;
                heap_rise(kept_n - 1);
                r.accepted = 1'b1;
            end else if (kept_n > 0 && !(sc < kept_score[0])) begin
                kept_score[0] = sc;
                kept_doc[0]   = doc;
                heap_sink();
                r.accepted = 1'b1;
            end
        end else if (kept_n > 0) begin
            r.popped_valid = 1'b1;
            r.popped_score = kept_score[0];
            r.popped_doc   = kept_doc[0];
            kept_n = kept_n - 1;
            kept_score[0] = kept_score[kept_n];
            kept_doc[0]   = kept_doc[kept_n];
            heap_sink();
        end
        if (kept_n >= k && kept_n > 0) r.min_score = kept_score[0];
        r.entry_count = COUNT_W'(kept_n);
        return r;
    endfunction

    // scores biased toward extremes and a few small repeated values for ties
    function automatic logic signed [SCORE_W-1:0] pick_score();
        logic signed [SCORE_W-1:0] v;
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(3))
                    0: v = 32'sh7FFF_FFFF;
                    1: v = 32'sh8000_0000;
                    2: v = 32'sh0000_0000;
                    default: v = 32'shFFFF_FFFF;
                endcase
            end
            1, 2: v = ($urandom_range(6) - 3) << 16;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // receiver stalls
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // result checker
    always @(posedge aclk) begin
        result_t seen;
        result_t want;
        if (m_tvalid && m_tready) begin
            seen.accepted     = m_tuser[0];
            seen.popped_valid = m_tuser[1];
            seen.popped_score = m_tdata[31:0];
            seen.popped_doc   = m_tdata[63:32];
            seen.min_score    = m_tdata[95:64];
            seen.entry_count  = m_tdata[106:96];
            if (predicted_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat: %p", seen);
            end else begin
                want = predicted_results.pop_front();
                if (seen.accepted !== want.accepted ||
                    seen.popped_valid !== want.popped_valid ||
                    seen.popped_score !== want.popped_score ||
                    seen.popped_doc !== want.popped_doc ||
                    seen.min_score !== want.min_score ||
                    seen.entry_count !== want.entry_count) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected %p actual %p", want, seen);
                end
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic set_idling(input int sender_idle, input int receiver_stall);
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
    endtask

    // send one command beat and record its expected result
    task automatic send_item(input logic cmd, input logic signed [SCORE_W-1:0] sc,
                             input logic [DOC_W-1:0] doc);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {doc, sc};
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        predicted_results.push_back(apply_heap_cmd(cmd, sc, doc));
    endtask

    // stop sending and wait until every result has come back
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (predicted_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [CFG_W-1:0] k);
        settle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= k;
        do @(posedge aclk); while (!cfg_ready);
        limit_reg = k;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int items, input int offer_pct);
        logic cmd;
        for (int i = 0; i < items; i++) begin
            cmd = ($urandom_range(99) < offer_pct) ? CMD_OFFER : CMD_POP;
            send_item(cmd, pick_score(), $urandom());
        end
    endtask

    // empty pop, score extremes, equal-to-root replace, reject below root
    task automatic test_order_extremes();
        set_idling(0, 0);
        set_capacity(11'd3);
        send_item(CMD_POP,   32'sh0000_0000, 32'h0000_0000);
        send_item(CMD_OFFER, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_OFFER, 32'sh8000_0000, 32'h0000_0000);
        send_item(CMD_OFFER, 32'sh0000_0000, 32'h5555_5555);
        send_item(CMD_OFFER, 32'sh8000_0000, 32'hAAAA_AAAA);
        send_item(CMD_OFFER, 32'shFFFF_0000, 32'h0000_0001);
        send_item(CMD_OFFER, 32'sh8000_0000, 32'h0000_0002);
        repeat (4) send_item(CMD_POP, 32'shFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // equal children: the left one moves up
    task automatic test_equal_children();
        send_item(CMD_OFFER, 32'sh0007_0000, 32'd10);
        send_item(CMD_OFFER, 32'sh0007_0000, 32'd11);
        send_item(CMD_OFFER, 32'sh0007_0000, 32'd12);
        send_item(CMD_OFFER, 32'sh0008_0000, 32'd13);
        repeat (3) send_item(CMD_POP, 32'sh0000_0000, 32'd0);
    endtask

    // limit of 0, saturated limit, limit lowered below the count
    task automatic test_limit_edges();
        set_capacity(11'd0);
        send_item(CMD_OFFER, 32'sh0003_0000, 32'd1);
        send_item(CMD_OFFER, 32'sh0002_0000, 32'd2);
        set_capacity(11'd2047);
        send_item(CMD_OFFER, 32'sh0001_0000, 32'd3);
        send_item(CMD_OFFER, 32'sh0004_0000, 32'd4);
        set_capacity(11'd1);
        send_item(CMD_OFFER, 32'sh0000_0000, 32'd5);
        send_item(CMD_OFFER, 32'sh0009_0000, 32'd6);
        repeat (3) send_item(CMD_POP, 32'sh0000_0000, 32'd0);
    endtask

    // random traffic across limits and idling patterns
    task automatic test_random_small_heaps();
        set_idling(0, 0);
        set_capacity(11'd1);
        run_random(100, 70);
        set_idling(81, 0);
        set_capacity(11'd2);
        run_random(150, 65);
        set_idling(0, 81);
        set_capacity(11'd17);
        run_random(200, 60);
        set_idling(25, 25);
        set_capacity(11'd0);
        run_random(100, 60);
    endtask

    // fill the whole store, then shrink the limit under the held count
    task automatic test_random_full_heap();
        set_idling(0, 0);
        set_capacity(11'd2047);
        run_random(1250, 96);
        set_idling(25, 25);
        set_capacity(11'd300);
        run_random(200, 50);
    endtask

    initial begin
        aresetn <= 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_order_extremes();
        test_equal_children();
        test_limit_edges();
        test_random_small_heaps();
        test_random_full_heap();

        settle();
        if (mismatch_count == 0 && predicted_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/tkh_pkg.sv
rtl/core/tkh_mem.sv
rtl/core/tkh_seq.sv
rtl/core/top_k_score_min_heap.sv
dv/tb_top_k_score_min_heap.sv
